/* hdl/mrf_pkg.sv */
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared types, constants and the CRC16 step for the Modbus RTU request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

	localparam int unsigned MAX_REGS_DEF = 123;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned REG_CNT_W = 7;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	localparam logic [1:0] MODE_RD_HOLD = 2'd0;
	localparam logic [1:0] MODE_RD_INPUT = 2'd1;
	localparam logic [1:0] MODE_WR_SINGLE = 2'd2;
	localparam logic [1:0] MODE_WR_MULTI = 2'd3;

	localparam logic [7:0] FC_RD_HOLD = 8'h03;
	localparam logic [7:0] FC_RD_INPUT = 8'h04;
	localparam logic [7:0] FC_WR_SINGLE = 8'h06;
	localparam logic [7:0] FC_WR_MULTI = 8'h10;

	typedef struct packed {
		logic        item_kind;
		logic [1:0]  mode;
		logic [7:0]  unit_id;
		logic [15:0] address;
		logic [15:0] count_or_value;
		logic [15:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic        hdr;
		logic        wm;
		logic        close;
		logic [7:0]  slave;
		logic [7:0]  code;
		logic [15:0] addr;
		logic [15:0] val;
	} cmd_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_SLAVE = 10'b00_0000_0010,
		ST_CODE  = 10'b00_0000_0100,
		ST_ADH   = 10'b00_0000_1000,
		ST_ADL   = 10'b00_0001_0000,
		ST_VH    = 10'b00_0010_0000,
		ST_VL    = 10'b00_0100_0000,
		ST_BC    = 10'b00_1000_0000,
		ST_CRCL  = 10'b01_0000_0000,
		ST_CRCH  = 10'b10_0000_0000
	} step_t;

	function automatic logic [7:0] func_code(input logic [1:0] mode);
		logic [7:0] fc;
		case (mode)
			MODE_RD_HOLD:   fc = FC_RD_HOLD;
			MODE_RD_INPUT:  fc = FC_RD_INPUT;
			MODE_WR_SINGLE: fc = FC_WR_SINGLE;
			MODE_WR_MULTI:  fc = FC_WR_MULTI;
			default:        fc = FC_RD_HOLD;
		endcase
		return fc;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hdl/modbus_rtu_request_framer.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// A request passes the command queue and the serialiser before its first byte
// reaches the output register. Throughput: one frame byte per cycle while the
// output is popped; a header gives 7 to 9 bytes, a data word 2 to 4, and an
// idle serialiser loads first. Serialiser and output register set the rate.
// Reset: asynchronous, clears the queue, open frame and CRC to 0xFFFF.
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer #(
	parameter int unsigned MAX_REGS = mrf_pkg::MAX_REGS_DEF,
	parameter int unsigned QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mrf_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output mrf_pkg::out_item_t result
);
	import mrf_pkg::*;

	logic q_wr;
	logic q_rd;
	logic q_full;
	logic q_empty;
	cmd_t q_wcmd;
	cmd_t q_rcmd;

	assign full = q_full;

	mrf_front #(
		.MAX_REGS(MAX_REGS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.q_full(q_full),
		.item(item),
		.q_wr(q_wr),
		.q_cmd(q_wcmd)
	);

	mrf_cmd_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_wr),
		.wdata(q_wcmd),
		.full(q_full),
		.rd(q_rd),
		.rdata(q_rcmd),
		.empty(q_empty)
	);

	mrf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_cmd(q_rcmd),
		.q_rd(q_rd),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule

/* hdl/mrf_front.sv */
// ----------------------------------------------------------------------------
// mrf_front
// Accepts request items, tracks the open write-multiple frame and turns each
// request into a framing command for the serialiser.
// ----------------------------------------------------------------------------
module mrf_front #(
	parameter int unsigned MAX_REGS = mrf_pkg::MAX_REGS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              q_full,
	input  mrf_pkg::in_item_t item,
	output logic              q_wr,
	output mrf_pkg::cmd_t     q_cmd
);
	import mrf_pkg::*;

	logic                 frame_open_q;
	logic [REG_CNT_W-1:0] left_q;
	logic                 accept;
	logic                 is_wm;
	logic [15:0]          sat_cv;
	logic                 last_reg;

	assign accept = push && !q_full;
	assign is_wm = (item.mode == MODE_WR_MULTI);
	assign sat_cv = (is_wm && (item.count_or_value > 16'(MAX_REGS))) ? 16'(MAX_REGS)
		: item.count_or_value;
	assign last_reg = (left_q == REG_CNT_W'(1));

	always_comb begin
		q_cmd = '0;
		q_wr = 1'b0;
		if (item.item_kind == KIND_HEADER) begin
			q_wr = accept;
			q_cmd.hdr = 1'b1;
			q_cmd.wm = is_wm;
			q_cmd.close = !is_wm || (sat_cv == 16'h0000);
			q_cmd.slave = item.unit_id;
			q_cmd.code = func_code(item.mode);
			q_cmd.addr = item.address;
			q_cmd.val = sat_cv;
		end else begin
			q_wr = accept && frame_open_q;
			q_cmd.hdr = 1'b0;
			q_cmd.wm = 1'b0;
			q_cmd.close = last_reg;
			q_cmd.val = item.data_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			left_q <= '0;
		end else if (accept) begin
			if (item.item_kind == KIND_HEADER) begin
				frame_open_q <= is_wm && (sat_cv != 16'h0000);
				left_q <= is_wm ? sat_cv[REG_CNT_W-1:0] : '0;
			end else if (frame_open_q) begin
				left_q <= left_q - REG_CNT_W'(1);
				if (last_reg) begin
					frame_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

/* hdl/mrf_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// mrf_cmd_fifo
// Short command queue between the front end and the serialiser.
// ----------------------------------------------------------------------------
module mrf_cmd_fifo #(
	parameter int unsigned DEPTH = mrf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  mrf_pkg::cmd_t wdata,
	output logic          full,
	input  logic          rd,
	output mrf_pkg::cmd_t rdata,
	output logic          empty
);
	import mrf_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

/* hdl/mrf_back.sv */
// ----------------------------------------------------------------------------
// mrf_back
// Serialises framing commands into bytes, keeps the running CRC16 and holds
// each byte in an output register until it is taken.
// ----------------------------------------------------------------------------
module mrf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  mrf_pkg::cmd_t      q_cmd,
	output logic               q_rd,
	output logic               empty,
	input  logic               pop,
	output mrf_pkg::out_item_t result
);
	import mrf_pkg::*;

	cmd_t        cmd_q;
	step_t       step_q;
	step_t       step_nxt;
	logic [15:0] crc_q;
	logic [15:0] crc_in;
	logic [7:0]  byte_d;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        ovalid_q;
	logic        busy;
	logic        emit;
	logic        load;

	assign busy = (step_q != ST_IDLE);
	assign emit = busy && (!ovalid_q || pop);
	assign load = !q_empty && (!busy || (emit && step_nxt == ST_IDLE));
	assign q_rd = load;
	assign empty = !ovalid_q;
	assign result.frame_byte = byte_q;
	assign result.frame_last = last_q;
	assign crc_in = (step_q == ST_SLAVE) ? CRC_INIT : crc_q;

	always_comb begin
		byte_d = 8'h00;
		step_nxt = ST_IDLE;
		case (step_q)
			ST_SLAVE: begin
				byte_d = cmd_q.slave;
				step_nxt = ST_CODE;
			end
			ST_CODE: begin
				byte_d = cmd_q.code;
				step_nxt = ST_ADH;
			end
			ST_ADH: begin
				byte_d = cmd_q.addr[15:8];
				step_nxt = ST_ADL;
			end
			ST_ADL: begin
				byte_d = cmd_q.addr[7:0];
				step_nxt = ST_VH;
			end
			ST_VH: begin
				byte_d = cmd_q.val[15:8];
				step_nxt = ST_VL;
			end
			ST_VL: begin
				byte_d = cmd_q.val[7:0];
				step_nxt = cmd_q.wm ? ST_BC : (cmd_q.close ? ST_CRCL : ST_IDLE);
			end
			ST_BC: begin
				byte_d = {cmd_q.val[6:0], 1'b0};
				step_nxt = cmd_q.close ? ST_CRCL : ST_IDLE;
			end
			ST_CRCL: begin
				byte_d = crc_q[7:0];
				step_nxt = ST_CRCH;
			end
			ST_CRCH: begin
				byte_d = crc_q[15:8];
				step_nxt = ST_IDLE;
			end
			default: begin
				byte_d = 8'h00;
				step_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= q_cmd;
		end
		if (emit) begin
			byte_q <= byte_d;
			last_q <= (step_q == ST_CRCH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			crc_q <= CRC_INIT;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q <= q_cmd.hdr ? ST_SLAVE : ST_VH;
			end else if (emit) begin
				step_q <= step_nxt;
			end
			if (emit) begin
				if (step_q == ST_CRCH) begin
					crc_q <= CRC_INIT;
				end else if (step_q != ST_CRCL) begin
					crc_q <= crc_byte(crc_in, byte_d);
				end
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule
